[hdl/ptdt_pkg.sv]
// package for the periodic task dispatch table
// types, operation and status codes shared by controller, datapath and top
`timescale 1ns / 1ps
`default_nettype none
package ptdt_pkg;
  localparam int DefSlotCount = 16;
  localparam int MaxResults = 16;
  localparam logic [15:0] HalfRange = 16'h7fff;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_DELAY = 3'd3;
  localparam logic [2:0] OP_SET_STATE = 3'd4;
  localparam logic [2:0] OP_START = 3'd5;
  localparam logic [2:0] OP_PAUSE = 3'd6;
  localparam logic [2:0] OP_CLEAR = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NEG = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_APPLY, S_TRIM, S_SCAN, S_MIN, S_CLEAR, S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic find_start; // reset scan index and flags
    logic find_step;  // look at one slot for id / free slot
    logic apply;      // write the found slot
    logic trim_step;  // pull used count back one empty slot
    logic tick_start; // advance time base, reset scan
    logic scan_step;  // test one slot for due
    logic min_start;  // seed earliest search
    logic min_step;   // fold one slot into earliest
    logic min_done;   // store earliest
    logic clear_step; // clear one slot
    logic clear_start;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;   // index reached used count (or slot count), or result limit reached
    logic clear_end;
    logic trim_end;
    logic fire;       // current scan slot is due
    logic skip;       // tick does nothing
    logic enabled;
  } dp_stat_t;
endpackage
`default_nettype wire

[hdl/ptdt_datapath.sv]
// datapath of the task table: slot registers, scan index, time base
// depends on ptdt_pkg
`timescale 1ns / 1ps
`default_nettype none
module ptdt_datapath #(
  parameter int SlotCount = ptdt_pkg::DefSlotCount
) (
  input  wire  logic              clk_i,
  input  wire  logic              rst_ni,
  input  wire  ptdt_pkg::dp_cmd_t cmd_i,
  input  wire  logic [2:0]        op_i,
  input  wire  logic [7:0]        id_i,
  input  wire  logic [15:0]       per_i,
  input  wire  logic [15:0]       dly_i,
  input  wire  logic              en_i,
  output ptdt_pkg::dp_stat_t      stat_o,
  output logic [1:0]              status_o,
  output logic [7:0]              fire_id_o
);
  import ptdt_pkg::*;
  localparam int IW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int CW = $clog2(SlotCount + 1);

  logic [7:0]  id_q [SlotCount];
  logic [SlotCount-1:0] act_q;
  logic [14:0] per_q [SlotCount];
  logic [15:0] due_q [SlotCount];
  logic [15:0] tb_q, early_q, best_q;
  logic [CW-1:0] used_q, idx_q;
  logic        en_q;
  logic [2:0]  op_q;
  logic [7:0]  tid_q;
  logic [15:0] tper_q, tdly_q;
  logic        ten_q;
  logic        found_q, free_q;
  logic        trim_q;      // removed slot was the highest used one
  logic [IW-1:0] fidx_q, freeidx_q;
  logic [4:0]  nfire_q;

  logic [IW-1:0] ix;
  logic [IW-1:0] tix;
  logic in_used, at_slot_end, due_now, dn_best, tgt_ok;
  logic [15:0] tb_next;

  assign ix = idx_q[IW-1:0];
  assign tix = used_q[IW-1:0] - 1'b1;
  assign at_slot_end = (idx_q == CW'(SlotCount));
  assign in_used = (idx_q < used_q) && !at_slot_end;
  assign due_now = act_q[ix] && (id_q[ix] != 8'd0) &&
                   ((due_q[ix] == tb_q) || (due_q[ix] - tb_q) >= 16'h8000);
  assign dn_best = ((due_q[ix] - best_q) >= 16'h8000);
  assign tb_next = tb_q + 16'd1;

  assign stat_o.scan_end = !in_used || (nfire_q == 5'(MaxResults));
  assign stat_o.clear_end = at_slot_end;
  assign stat_o.trim_end = !trim_q || (used_q == '0) || (id_q[tix] != 8'd0);
  assign stat_o.fire = due_now;
  assign stat_o.enabled = en_q;
  assign stat_o.skip = (early_q != tb_q) && ((early_q - tb_q) < 16'h8000);
  assign fire_id_o = id_q[ix];

  // status of a non-tick operation once the find scan is done
  always_comb begin
    tgt_ok = 1'b0;
    status_o = ST_OK;
    case (op_q)
      OP_ADD: begin
        if (tper_q[15] || tdly_q[15]) status_o = ST_NEG;
        else if (tid_q == 8'd0) status_o = ST_NOTFOUND;
        else if (!found_q && !free_q) status_o = ST_FULL;
        else tgt_ok = 1'b1;
      end
      OP_DELAY: begin
        if (tdly_q[15]) status_o = ST_NEG;
        else if (tid_q == 8'd0 || !found_q) status_o = ST_NOTFOUND;
        else tgt_ok = 1'b1;
      end
      OP_REMOVE, OP_SET_STATE: begin
        if (tid_q == 8'd0 || !found_q) status_o = ST_NOTFOUND;
        else tgt_ok = 1'b1;
      end
      default: status_o = ST_OK;
    endcase
  end

  logic [IW-1:0] tslot;
  assign tslot = found_q ? fidx_q : freeidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
      for (int i = 0; i < SlotCount; i++) begin
        id_q[i] <= 8'd0;
        per_q[i] <= 15'd0;
        due_q[i] <= 16'd0;
      end
      tb_q <= 16'd0;
      early_q <= 16'd0;
      best_q <= 16'd0;
      used_q <= '0;
      en_q <= 1'b0;
      idx_q <= '0;
      found_q <= 1'b0;
      free_q <= 1'b0;
      trim_q <= 1'b0;
      fidx_q <= '0;
      freeidx_q <= '0;
      nfire_q <= 5'd0;
    end else begin
      if (cmd_i.find_start || cmd_i.tick_start || cmd_i.min_start || cmd_i.clear_start) begin
        idx_q <= '0;
      end
      if (cmd_i.find_start) begin
        found_q <= 1'b0;
        free_q <= 1'b0;
        trim_q <= 1'b0;
      end
      if (cmd_i.find_step) begin
        if (!at_slot_end) begin
          if (in_used && !found_q && id_q[ix] == tid_q) begin
            found_q <= 1'b1;
            fidx_q <= ix;
          end
          if (!free_q && id_q[ix] == 8'd0) begin
            free_q <= 1'b1;
            freeidx_q <= ix;
          end
          idx_q <= idx_q + 1'b1;
        end
      end
      if (cmd_i.apply) begin
        case (op_q)
          OP_ADD: if (tgt_ok) begin
            id_q[tslot] <= tid_q;
            act_q[tslot] <= 1'b1;
            per_q[tslot] <= tper_q[14:0];
            due_q[tslot] <= tb_q + tdly_q;
            if (!found_q && CW'(freeidx_q) >= used_q) used_q <= CW'(freeidx_q) + 1'b1;
          end
          OP_REMOVE: if (tgt_ok) begin
            id_q[fidx_q] <= 8'd0;
            act_q[fidx_q] <= 1'b0;
            per_q[fidx_q] <= 15'd0;
            due_q[fidx_q] <= 16'd0;
            trim_q <= (CW'(fidx_q) + 1'b1 == used_q);
            if (CW'(fidx_q) + 1'b1 == used_q) used_q <= used_q - 1'b1;
          end
          OP_DELAY: if (tgt_ok) due_q[fidx_q] <= tb_q + tdly_q;
          OP_SET_STATE: if (tgt_ok) begin
            act_q[fidx_q] <= ten_q;
            due_q[fidx_q] <= tb_q + {1'b0, per_q[fidx_q]};
          end
          OP_START: begin
            en_q <= 1'b1;
            early_q <= tb_q;
          end
          OP_PAUSE: en_q <= 1'b0;
          default: ;
        endcase
      end
      if (cmd_i.trim_step) used_q <= used_q - 1'b1;
      if (cmd_i.tick_start) begin
        tb_q <= tb_next;
        nfire_q <= 5'd0;
      end
      if (cmd_i.scan_step) begin
        if (due_now) begin
          due_q[ix] <= tb_q + {1'b0, per_q[ix]};
          if (per_q[ix] == 15'd0) id_q[ix] <= 8'd0;
          nfire_q <= nfire_q + 5'd1;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.min_start) best_q <= tb_q + HalfRange;
      if (cmd_i.min_step) begin
        if (act_q[ix] && id_q[ix] != 8'd0 && dn_best) best_q <= due_q[ix];
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.min_done) early_q <= best_q;
      if (cmd_i.clear_step) begin
        id_q[ix] <= 8'd0;
        act_q[ix] <= 1'b0;
        per_q[ix] <= 15'd0;
        due_q[ix] <= 16'd0;
        idx_q <= idx_q + 1'b1;
        tb_q <= 16'd0;
        early_q <= 16'd0;
        used_q <= '0;
        en_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      tid_q <= id_i;
      tper_q <= per_i;
      tdly_q <= dly_i;
      ten_q <= en_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= CW'(SlotCount))
    else $error("used count beyond slot count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) nfire_q <= 5'(MaxResults))
    else $error("too many fired in one tick");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick_start |=> tb_q == $past(tb_q) + 16'd1)
    else $error("time base did not advance");
endmodule
`default_nettype wire

[hdl/ptdt_ctrl.sv]
// controller state machine of the task table, owns the stream handshakes
// depends on ptdt_pkg
`timescale 1ns / 1ps
`default_nettype none
module ptdt_ctrl (
  input  wire  logic               clk_i,
  input  wire  logic               rst_ni,
  input  wire  logic               in_valid_i,
  output logic                     in_ready_o,
  input  wire  logic [2:0]         in_op_i,
  input  wire  logic [2:0]         op_i,
  input  wire  ptdt_pkg::dp_stat_t stat_i,
  input  wire  logic [1:0]         status_i,
  input  wire  logic [7:0]         fire_id_i,
  output ptdt_pkg::dp_cmd_t        cmd_o,
  output logic                     out_valid_o,
  input  wire  logic               out_ready_i,
  output logic [11:0]              out_word_o
);
  import ptdt_pkg::*;
  state_e state_q, state_d;
  logic ov_q, ov_d;
  logic [11:0] ow_q, ow_d;
  logic any_q, any_d;
  logic pend_q, pend_d;       // tick result waiting for a free output reg
  logic [7:0] pid_q, pid_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_word_o = ow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
      any_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
      any_q <= any_d;
      pend_q <= pend_d;
    end
  end
  always_ff @(posedge clk_i) begin
    ow_q <= ow_d;
    pid_q <= pid_d;
  end

  // word layout: status, fired, fired_task_id, last
  always_comb begin
    logic free;
    free = !ov_q || out_ready_i;
    state_d = state_q;
    cmd_o = '0;
    ov_d = ov_q && !out_ready_i;
    ow_d = ow_q;
    any_d = any_q;
    pend_d = pend_q;
    pid_d = pid_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (in_op_i)
            OP_TICK: state_d = S_SCAN;
            OP_CLEAR: begin
              cmd_o.clear_start = 1'b1;
              state_d = S_CLEAR;
            end
            OP_START, OP_PAUSE: state_d = S_APPLY;
            default: begin
              cmd_o.find_start = 1'b1;
              state_d = S_FIND;
            end
          endcase
          any_d = 1'b0;
          pend_d = 1'b0;
        end
      end
      S_FIND: begin
        cmd_o.find_step = 1'b1;
        if (stat_i.clear_end) state_d = S_APPLY;
      end
      S_APPLY: if (free) begin
        cmd_o.apply = 1'b1;
        ov_d = 1'b1;
        ow_d = {1'b1, 8'd0, 1'b0, status_i};
        if (op_i == OP_PAUSE) state_d = S_IDLE;
        else if (op_i == OP_REMOVE) state_d = S_TRIM;
        else begin
          cmd_o.min_start = 1'b1;
          state_d = S_MIN;
        end
      end
      S_TRIM: begin
        if (stat_i.trim_end) begin
          cmd_o.min_start = 1'b1;
          state_d = S_MIN;
        end else cmd_o.trim_step = 1'b1;
      end
      S_SCAN: begin
        if (!stat_i.enabled) begin
          if (free) begin
            ov_d = 1'b1;
            ow_d = {1'b1, 8'd0, 1'b0, ST_OK};
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.tick_start = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // skip test, then scan one slot a cycle unless a due slot waits on a stalled output; one fired word held back
        if (!any_q && !pend_q && stat_i.skip) begin
          if (free) begin
            ov_d = 1'b1;
            ow_d = {1'b1, 8'd0, 1'b0, ST_OK};
            state_d = S_IDLE;
          end
        end else if (!stat_i.scan_end) begin
          any_d = 1'b1;
          if (!stat_i.fire) cmd_o.scan_step = 1'b1;
          else if (!pend_q) begin
            cmd_o.scan_step = 1'b1;
            pend_d = 1'b1;
            pid_d = fire_id_i;
          end else if (free) begin
            cmd_o.scan_step = 1'b1;
            ov_d = 1'b1;
            ow_d = {1'b0, pid_q, 1'b1, ST_OK};
            pid_d = fire_id_i;
          end
        end else if (free) begin
          ov_d = 1'b1;
          ow_d = pend_q ? {1'b1, pid_q, 1'b1, ST_OK} : {1'b1, 8'd0, 1'b0, ST_OK};
          pend_d = 1'b0;
          cmd_o.min_start = 1'b1;
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        if (stat_i.clear_end) begin
          cmd_o.min_done = 1'b1;
          state_d = S_IDLE;
        end else cmd_o.min_step = 1'b1;
      end
      S_CLEAR: begin
        if (stat_i.clear_end) begin
          if (free) begin
            ov_d = 1'b1;
            ow_d = {1'b1, 8'd0, 1'b0, ST_OK};
            state_d = S_IDLE;
          end
        end else cmd_o.clear_step = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> ov_q)
    else $error("output word dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_q)
    else $error("fired word pending at idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.scan_step, cmd_o.min_step, cmd_o.find_step, cmd_o.clear_step}))
    else $error("two scans at once");
endmodule
`default_nettype wire

[hdl/periodic_task_dispatch_table.sv]
// top level of the periodic task dispatch table
// depends on ptdt_pkg, ptdt_ctrl, ptdt_datapath
//
// channel   dir  tdata (low bit up)                 tuser       tlast
// s_axis    in   task_id, period, delay, enable     operation   -
// m_axis    out  status, fired_task_id              fired       last
//
// one word at a time; a non-tick op runs accept, id/free search, apply, then the
// earliest recompute, both scans over every slot; remove adds a trim step per
// trimmed slot; start skips the search, pause is accept and apply only; a tick
// stops after accept if paused, after skip test if skipped, else it scans used
// slots and recomputes earliest; clear steps through each slot; output stalls hold
// the scan; reset clears all slots at once; the input waits until the word is done
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_dispatch_table #(
  parameter int SlotCount = ptdt_pkg::DefSlotCount
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [47:0] s_axis_tdata,  // task_id, period_ticks, delay_ticks, enable_state
  input  wire  logic [2:0]  s_axis_tuser,  // operation
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output logic [15:0]       m_axis_tdata,  // status, fired_task_id
  output logic              m_axis_tuser,  // fired
  output logic              m_axis_tlast
);
  import ptdt_pkg::*;
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [1:0] status;
  logic [7:0] fire_id;
  logic [11:0] word;
  logic [2:0] op_q;

  // held op for the controller's branching
  always_ff @(posedge clk_i) begin
    if (cmd.load) op_q <= s_axis_tuser;
  end

  ptdt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_op_i(s_axis_tuser), .op_i(op_q),
    .stat_i(stat), .status_i(status), .fire_id_i(fire_id),
    .cmd_o(cmd), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_word_o(word)
  );

  ptdt_datapath #(.SlotCount(SlotCount)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .op_i(s_axis_tuser), .id_i(s_axis_tdata[7:0]),
    .per_i(s_axis_tdata[23:8]), .dly_i(s_axis_tdata[39:24]),
    .en_i(s_axis_tdata[40]),
    .stat_o(stat), .status_o(status), .fire_id_o(fire_id)
  );

  // word: last, fired_task_id, fired, status
  assign m_axis_tdata = {6'd0, word[10:3], word[1:0]};
  assign m_axis_tuser = word[2];
  assign m_axis_tlast = word[11];
endmodule
`default_nettype wire

[tb/tb.sv]
// testbench for periodic_task_dispatch_table
// depends on ptdt_pkg and the top level; drives operation words, checks each result word
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import ptdt_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0] status;
    logic       fired;
    logic [7:0] task_id;
    logic       last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  periodic_task_dispatch_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the slot table
  logic [7:0]  tbl_id [NSLOT];
  logic        tbl_act [NSLOT];
  logic [14:0] tbl_per [NSLOT];
  logic [15:0] tbl_due [NSLOT];
  logic [15:0] now_q, soonest_q;
  int          used_q;
  logic        run_q;

  result_t pending_q[$];
  int errors = 0, words_in = 0, words_out = 0, fires_seen = 0;
  int send_idle = 0, recv_idle = 0;
  longint cycles = 0;

  function automatic bit is_neg(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return d[15];
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < NSLOT; i++) begin
      tbl_id[i] = 0; tbl_act[i] = 0; tbl_per[i] = 0; tbl_due[i] = 0;
    end
    now_q = 0; soonest_q = 0; used_q = 0; run_q = 0;
  endfunction

  function automatic void find_soonest();
    logic [15:0] best;
    best = now_q + HalfRange;
    for (int i = 0; i < used_q; i++)
      if (tbl_act[i] && tbl_id[i] != 0 && is_neg(tbl_due[i], best)) best = tbl_due[i];
    soonest_q = best;
  endfunction

  function automatic int slot_of(logic [7:0] id);
    for (int i = 0; i < used_q; i++) if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void push_result(logic [1:0] st, logic f, logic [7:0] id, logic l);
    result_t r;
    r.status = st; r.fired = f; r.task_id = id; r.last = l;
    pending_q.push_back(r);
  endfunction

  function automatic void run_tick();
    int n;
    n = 0;
    if (!run_q) begin
      push_result(ST_OK, 0, 0, 1);
      return;
    end
    now_q = now_q + 1;
    if (soonest_q != now_q && !is_neg(soonest_q, now_q)) begin
      push_result(ST_OK, 0, 0, 1);
      return;
    end
    for (int i = 0; i < used_q && n < MaxResults; i++)
      if (tbl_act[i] && tbl_id[i] != 0 &&
          (tbl_due[i] == now_q || is_neg(tbl_due[i], now_q))) begin
        push_result(ST_OK, 1, tbl_id[i], 0);
        n++;
        tbl_due[i] = now_q + {1'b0, tbl_per[i]};
        if (tbl_per[i] == 0) tbl_id[i] = 0;
      end
    find_soonest();
    if (n == 0) push_result(ST_OK, 0, 0, 1);
    else pending_q[pending_q.size() - 1].last = 1;
  endfunction

  // predicts the results of one operation word
  function automatic void predict_word(logic [2:0] op, logic [7:0] id,
                                       logic [15:0] per, logic [15:0] dly, logic en);
    logic [1:0] st;
    int s, k;
    st = ST_OK;
    case (op)
      OP_TICK: begin
        run_tick();
        return;
      end
      OP_ADD: begin
        if (per[15] || dly[15]) st = ST_NEG;
        else if (id == 0) st = ST_NOTFOUND;
        else begin
          s = slot_of(id);
          if (s < 0) begin
            k = 0;
            while (k < NSLOT && tbl_id[k] != 0) k++;
            if (k == NSLOT) st = ST_FULL;
            else begin
              s = k; tbl_id[k] = id;
              if (k >= used_q) used_q = k + 1;
            end
          end
          if (st == ST_OK) begin
            tbl_act[s] = 1; tbl_per[s] = per[14:0]; tbl_due[s] = now_q + dly;
            find_soonest();
          end
        end
      end
      OP_REMOVE: begin
        s = (id == 0) ? -1 : slot_of(id);
        if (s < 0) st = ST_NOTFOUND;
        else begin
          tbl_id[s] = 0; tbl_act[s] = 0; tbl_per[s] = 0; tbl_due[s] = 0;
          if (s + 1 == used_q) begin
            used_q--;
            while (used_q != 0 && tbl_id[used_q - 1] == 0) used_q--;
          end
          find_soonest();
        end
      end
      OP_DELAY: begin
        if (dly[15]) st = ST_NEG;
        else begin
          s = (id == 0) ? -1 : slot_of(id);
          if (s < 0) st = ST_NOTFOUND;
          else begin
            tbl_due[s] = now_q + dly;
            find_soonest();
          end
        end
      end
      OP_SET_STATE: begin
        s = (id == 0) ? -1 : slot_of(id);
        if (s < 0) st = ST_NOTFOUND;
        else begin
          tbl_act[s] = en; tbl_due[s] = now_q + {1'b0, tbl_per[s]};
          find_soonest();
        end
      end
      OP_START: begin
        run_q = 1;
        find_soonest();
      end
      OP_PAUSE: run_q = 0;
      default: table_reset();
    endcase
    push_result(st, 0, 0, 1);
  endfunction

  // one word in: drive at the falling edge, wait for the handshake
  task automatic send_word(logic [2:0] op, logic [7:0] id, logic [15:0] per,
                           logic [15:0] dly, logic en);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {7'b0, en, dly, per, id};
    s_axis_tuser <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_word(op, id, per, dly, en);
    words_in++;
  endtask

  // receiver side: random stall set at the falling edge
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_idle);

  // compares each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[1:0], m_axis_tuser, m_axis_tdata[9:2], m_axis_tlast};
      words_out++;
      if (got.fired) fires_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: got %h", $time, got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got !== want || m_axis_tdata[15:10] !== 6'b0) begin
          $display("%0t mismatch: expected st=%0d f=%0d id=%0d last=%0d, got st=%0d f=%0d id=%0d last=%0d",
                   $time, want.status, want.fired, want.task_id, want.last,
                   got.status, got.fired, got.task_id, got.last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[periodic_task_dispatch_table] ERROR");
      $finish;
    end
  end

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_s16();
    return 16'($urandom_range(65535));
  endfunction

  // field extremes, every operation, error codes and one-shot cases
  task automatic test_directed();
    send_word(OP_TICK, 0, 0, 0, 0);              // disabled tick
    send_word(OP_ADD, 0, 0, 0, 0);               // id zero
    send_word(OP_ADD, 8'd5, 16'h8000, 0, 0);     // negative period
    send_word(OP_ADD, 8'd5, 0, 16'hffff, 0);     // negative delay
    send_word(OP_ADD, 8'd255, 16'h7fff, 16'h7fff, 1);
    send_word(OP_ADD, 8'd1, 0, 16'd1, 0);        // one-shot
    send_word(OP_ADD, 8'd2, 16'd1, 0, 0);
    send_word(OP_ADD, 8'd2, 16'd2, 16'd2, 0);    // rewrite known id
    send_word(OP_REMOVE, 8'd77, 0, 0, 0);        // not found
    send_word(OP_DELAY, 8'd9, 0, 16'h8000, 0);
    send_word(OP_DELAY, 8'd255, 0, 0, 0);
    send_word(OP_SET_STATE, 8'd255, 0, 0, 0);
    send_word(OP_START, 0, 16'hffff, 16'hffff, 1);
    repeat (4) send_word(OP_TICK, 0, 0, 0, 0);   // one-shot fires and frees
    send_word(OP_SET_STATE, 8'd255, 0, 0, 1);
    send_word(OP_PAUSE, 0, 0, 0, 0);
    send_word(OP_TICK, 8'hff, 16'hffff, 16'hffff, 1);
    send_word(OP_REMOVE, 8'd255, 0, 0, 0);       // frees slot zero; used count stays
    for (int i = 1; i <= NSLOT; i++) send_word(OP_ADD, 8'(100 + i), 0, 0, 0);
    send_word(OP_ADD, 8'd250, 0, 0, 0);          // table full
    send_word(OP_START, 0, 0, 0, 0);
    send_word(OP_TICK, 0, 0, 0, 0);              // fifteen fire at once
    send_word(OP_CLEAR, 0, 0, 0, 0);
    drain();                                     // sender waits for all results
  endtask

  // mostly well-formed task traffic with short periods so ticks fire often
  task automatic test_random(int count);
    logic [2:0] op;
    logic [7:0] id;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? 8'(rand_s16()) : 8'($urandom_range(1, 20));
      if (r < 45) op = OP_TICK;
      else if (r < 65) op = OP_ADD;
      else if (r < 72) op = OP_REMOVE;
      else if (r < 79) op = OP_DELAY;
      else if (r < 86) op = OP_SET_STATE;
      else if (r < 93) op = OP_START;
      else if (r < 98) op = OP_PAUSE;
      else op = OP_CLEAR;
      if ($urandom_range(7) == 0)
        send_word(op, id, rand_s16(), rand_s16(), 1'($urandom_range(1)));
      else
        send_word(op, id, 16'($urandom_range(6)), 16'($urandom_range(8)),
                  1'($urandom_range(1)));
    end
  endtask

  initial begin
    table_reset();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle = 37; recv_idle = 73;
    test_directed();
    test_random(100);
    send_idle = 73; recv_idle = 37;
    test_random(100);
    send_idle = 0; recv_idle = 0;
    test_random(90);
    drain();
    $display("sent %0d words, checked %0d results, %0d task firings, %0d errors",
             words_in, words_out, fires_seen, errors);
    if (errors == 0) $display("[periodic_task_dispatch_table] OK");
    else $display("[periodic_task_dispatch_table] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
